// File: src/smwg_pkg.sv
// Package for the segmented memory with write guard: sizes, codes and the
// request record passed from the classifier to the executor.
// No dependencies.
`default_nettype none

package smwg_pkg;

  localparam int unsigned TEXT_WORDS  = 64;
  localparam int unsigned DATA_WORDS  = 64;
  localparam int unsigned STACK_WORDS = 64;

  localparam int unsigned TEXT_AW  = (TEXT_WORDS > 1) ? $clog2(TEXT_WORDS) : 1;
  localparam int unsigned DATA_AW  = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int unsigned STACK_AW = (STACK_WORDS > 1) ? $clog2(STACK_WORDS) : 1;
  localparam int unsigned TEXT_CNT_W = $clog2(TEXT_WORDS + 1);

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned SEG_W  = 4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [SEG_W-1:0] SEG_TEXT  = 4'd1;
  localparam logic [SEG_W-1:0] SEG_DATA  = 4'd2;
  localparam logic [SEG_W-1:0] SEG_STACK = 4'd3;

  localparam logic [WORD_W-1:0] FAULT_RESET = 32'h0000_3000;

  // Register index on the configuration port.
  localparam logic REG_FAULT = 1'b0;

  typedef enum logic [2:0] {
    CMD_LOAD_CODE = 3'd0,
    CMD_LOAD_DATA = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ_WORD = 3'd3,
    CMD_READ_BYTE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_PROTECT  = 3'd1,
    ST_RANGE    = 3'd2,
    ST_UNMAPPED = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_TEXT  = 2'd1,
    TGT_DATA  = 2'd2,
    TGT_STACK = 2'd3
  } tgt_e;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    tgt_e              tgt;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] wdata;
    logic              is_byte;
    logic [1:0]        lane;
    status_e           status;
  } req_t;

endpackage

`default_nettype wire

// File: src/segmented_memory_with_write_guard.sv
// Top level of the segmented memory with write guard: configuration
// register, classifier, request queue and executor.
// Depends on smwg_pkg, smwg_front, smwg_queue and smwg_back.
//
//   Channel   Direction  Handshake                      Payload
//   command   in         start && !busy                 cmd_i, address_i, write_word_i,
//                                                       byte_lane_i
//   result    out        done_o (one-cycle strobe)      read_word_o, status_o
//   config    in         psel && penable && pwrite      paddr, pwdata (prdata on reads)
//
// A command may be issued every cycle. Its result strobes after the request
// has passed through the queue, the store read and the result register. The
// executor drains one request per cycle and the result side cannot stall, so
// the queue never holds more than one request and busy stays low in practice.
// Reset clears the valid bits of all three stores and the fill counter at
// once; there is no clearing pass.
`default_nettype none

module segmented_memory_with_write_guard (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  cmd_i,
  input  wire  [15:0] address_i,
  input  wire  [31:0] write_word_i,
  input  wire  [1:0]  byte_lane_i,
  output logic        done_o,
  output logic [31:0] read_word_o,
  output logic [2:0]  status_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [smwg_pkg::WORD_W-1:0] fault_q;
  logic                        cfg_wr;
  logic                        accept;
  logic                        push;
  logic                        q_empty, q_full;
  smwg_pkg::req_t              front_req, back_req;

  // Configuration port. Every access completes in its access cycle; the
  // register index is the word address, paddr[2].
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == smwg_pkg::REG_FAULT);
  assign prdata = (paddr[2] == smwg_pkg::REG_FAULT) ? fault_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= smwg_pkg::FAULT_RESET;
    end else if (cfg_wr) begin
      fault_q <= pwdata;
    end
  end

  // A command transfers whenever the queue has room.
  assign busy   = q_full;
  assign accept = start && !busy;

  smwg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (cmd_i),
    .address_i    (address_i),
    .write_word_i (write_word_i),
    .byte_lane_i  (byte_lane_i),
    .push_o       (push),
    .req_o        (front_req)
  );

  smwg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (front_req),
    .pop_i   (!q_empty),
    .req_o   (back_req),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // The executor takes the oldest request every cycle that one is waiting.
  smwg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (!q_empty),
    .req_i       (back_req),
    .fault_i     (fault_q),
    .done_o      (done_o),
    .read_word_o (read_word_o),
    .status_o    (status_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("result did not follow the command after three cycles");

  a_no_data_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == 3'(smwg_pkg::ST_PROTECT) ||
                done_o && status_o == 3'(smwg_pkg::ST_FULL))) |-> (read_word_o == '0))
    else $error("write or load fault returned nonzero data");

  a_range_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == 3'(smwg_pkg::ST_RANGE)) |->
      (read_word_o == fault_q || read_word_o == '0))
    else $error("out-of-range result is neither the fault word nor zero");

endmodule

`default_nettype wire

// File: src/smwg_front.sv
// Front end: decodes each accepted command, checks segment and range,
// and owns the code-load fill counter. Depends on smwg_pkg.
`default_nettype none

module smwg_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          accept_i,
  input  wire  [2:0]                   cmd_i,
  input  wire  [smwg_pkg::ADDR_W-1:0]  address_i,
  input  wire  [smwg_pkg::WORD_W-1:0]  write_word_i,
  input  wire  [1:0]                   byte_lane_i,
  output logic                         push_o,
  output smwg_pkg::req_t               req_o
);

  logic [smwg_pkg::TEXT_CNT_W-1:0] fill_q, fill_d;
  logic [smwg_pkg::SEG_W-1:0]      seg;
  logic [smwg_pkg::IDX_W-1:0]      idx;
  logic [smwg_pkg::IDX_W-1:0]      ridx;
  smwg_pkg::tgt_e                  rtgt;
  logic                            rin;
  logic                            text_free;

  assign seg = address_i[smwg_pkg::ADDR_W-1 -: smwg_pkg::SEG_W];
  assign idx = address_i[smwg_pkg::IDX_W-1:0];
  assign text_free = (fill_q < smwg_pkg::TEXT_CNT_W'(smwg_pkg::TEXT_WORDS));

  // Byte reads address the word that holds the byte.
  assign ridx = (smwg_pkg::cmd_e'(cmd_i) == smwg_pkg::CMD_READ_BYTE) ? (idx >> 2) : idx;

  always_comb begin
    rtgt = smwg_pkg::TGT_NONE;
    rin  = 1'b0;
    if (seg == smwg_pkg::SEG_TEXT) begin
      rtgt = smwg_pkg::TGT_TEXT;
      rin  = ({1'b0, ridx} < 13'(smwg_pkg::TEXT_WORDS));
    end else if (seg == smwg_pkg::SEG_DATA) begin
      rtgt = smwg_pkg::TGT_DATA;
      rin  = ({1'b0, ridx} < 13'(smwg_pkg::DATA_WORDS));
    end else if (seg == smwg_pkg::SEG_STACK) begin
      rtgt = smwg_pkg::TGT_STACK;
      rin  = ({1'b0, ridx} < 13'(smwg_pkg::STACK_WORDS));
    end
  end

  always_comb begin
    req_o.op      = smwg_pkg::OP_NOP;
    req_o.tgt     = smwg_pkg::TGT_NONE;
    req_o.idx     = idx;
    req_o.wdata   = write_word_i;
    req_o.is_byte = 1'b0;
    req_o.lane    = byte_lane_i;
    req_o.status  = smwg_pkg::ST_OK;
    fill_d        = fill_q;
    unique case (smwg_pkg::cmd_e'(cmd_i))
      smwg_pkg::CMD_LOAD_CODE: begin
        if (text_free) begin
          req_o.op  = smwg_pkg::OP_WRITE;
          req_o.tgt = smwg_pkg::TGT_TEXT;
          req_o.idx = smwg_pkg::IDX_W'(fill_q);
          if (accept_i) begin
            fill_d = fill_q + 1'b1;
          end
        end else begin
          req_o.status = smwg_pkg::ST_FULL;
        end
      end
      smwg_pkg::CMD_LOAD_DATA: begin
        // The segment bits play no part in a data load.
        if ({1'b0, idx} < 13'(smwg_pkg::DATA_WORDS)) begin
          req_o.op  = smwg_pkg::OP_WRITE;
          req_o.tgt = smwg_pkg::TGT_DATA;
        end else begin
          req_o.status = smwg_pkg::ST_RANGE;
        end
      end
      smwg_pkg::CMD_WRITE: begin
        if (rtgt == smwg_pkg::TGT_TEXT || rtgt == smwg_pkg::TGT_DATA) begin
          req_o.status = smwg_pkg::ST_PROTECT;
        end else if (rtgt == smwg_pkg::TGT_NONE) begin
          req_o.status = smwg_pkg::ST_UNMAPPED;
        end else if (rin) begin
          req_o.op  = smwg_pkg::OP_WRITE;
          req_o.tgt = smwg_pkg::TGT_STACK;
        end else begin
          req_o.status = smwg_pkg::ST_RANGE;
        end
      end
      smwg_pkg::CMD_READ_WORD, smwg_pkg::CMD_READ_BYTE: begin
        req_o.op      = smwg_pkg::OP_READ;
        req_o.tgt     = rtgt;
        req_o.idx     = ridx;
        req_o.is_byte = (smwg_pkg::cmd_e'(cmd_i) == smwg_pkg::CMD_READ_BYTE);
        if (rtgt == smwg_pkg::TGT_NONE) begin
          req_o.status = smwg_pkg::ST_UNMAPPED;
        end else if (!rin) begin
          req_o.status = smwg_pkg::ST_RANGE;
        end
      end
      default: begin
        req_o.op = smwg_pkg::OP_NOP;
      end
    endcase
  end

  assign push_o = accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= smwg_pkg::TEXT_CNT_W'(smwg_pkg::TEXT_WORDS))
    else $error("text fill count past the store size");

endmodule

`default_nettype wire

// File: src/smwg_queue.sv
// Short request queue between the classifier and the executor.
// Depends on smwg_pkg.
`default_nettype none

module smwg_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  smwg_pkg::req_t      req_i,
  input  wire                 pop_i,
  output smwg_pkg::req_t      req_o,
  output logic                empty_o,
  output logic                full_o
);

  smwg_pkg::req_t                   ent_q [smwg_pkg::QUEUE_DEPTH];
  logic [smwg_pkg::QPTR_W-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [smwg_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == smwg_pkg::QCNT_W'(smwg_pkg::QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign req_o   = ent_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == smwg_pkg::QPTR_W'(smwg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == smwg_pkg::QPTR_W'(smwg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: src/smwg_back.sv
// Back end: carries out queued requests on the three word stores and
// registers the result. Depends on smwg_pkg.
`default_nettype none

module smwg_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          pop_i,
  input  smwg_pkg::req_t               req_i,
  input  wire  [smwg_pkg::WORD_W-1:0]  fault_i,
  output logic                         done_o,
  output logic [smwg_pkg::WORD_W-1:0]  read_word_o,
  output logic [2:0]                   status_o
);

  logic [smwg_pkg::WORD_W-1:0] text_mem  [smwg_pkg::TEXT_WORDS];
  logic [smwg_pkg::WORD_W-1:0] data_mem  [smwg_pkg::DATA_WORDS];
  logic [smwg_pkg::WORD_W-1:0] stack_mem [smwg_pkg::STACK_WORDS];
  logic [smwg_pkg::TEXT_WORDS-1:0]  text_vld_q;
  logic [smwg_pkg::DATA_WORDS-1:0]  data_vld_q;
  logic [smwg_pkg::STACK_WORDS-1:0] stack_vld_q;

  logic [smwg_pkg::TEXT_AW-1:0]  text_addr;
  logic [smwg_pkg::DATA_AW-1:0]  data_addr;
  logic [smwg_pkg::STACK_AW-1:0] stack_addr;
  logic text_we, data_we, stack_we, is_write;

  logic [smwg_pkg::WORD_W-1:0] text_rd_q, data_rd_q, stack_rd_q;
  logic text_rv_q, data_rv_q, stack_rv_q;
  logic           s1_vld_q;
  smwg_pkg::req_t s1_q;

  logic [smwg_pkg::WORD_W-1:0] mem_word, src_word, res_word;
  logic [7:0]                  lane_byte;
  logic                        done_q;
  logic [smwg_pkg::WORD_W-1:0] word_q, word_d;
  logic [2:0]                  status_q;

  assign text_addr  = req_i.idx[smwg_pkg::TEXT_AW-1:0];
  assign data_addr  = req_i.idx[smwg_pkg::DATA_AW-1:0];
  assign stack_addr = req_i.idx[smwg_pkg::STACK_AW-1:0];
  assign is_write   = pop_i && (req_i.op == smwg_pkg::OP_WRITE);
  assign text_we    = is_write && (req_i.tgt == smwg_pkg::TGT_TEXT);
  assign data_we    = is_write && (req_i.tgt == smwg_pkg::TGT_DATA);
  assign stack_we   = is_write && (req_i.tgt == smwg_pkg::TGT_STACK);

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[text_addr] <= req_i.wdata;
    end
    text_rd_q <= text_mem[text_addr];
    text_rv_q <= text_vld_q[text_addr];
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_addr] <= req_i.wdata;
    end
    data_rd_q <= data_mem[data_addr];
    data_rv_q <= data_vld_q[data_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_addr] <= req_i.wdata;
    end
    stack_rd_q <= stack_mem[stack_addr];
    stack_rv_q <= stack_vld_q[stack_addr];
  end

  // A word never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_vld_q  <= '0;
      data_vld_q  <= '0;
      stack_vld_q <= '0;
    end else begin
      if (text_we) begin
        text_vld_q[text_addr] <= 1'b1;
      end
      if (data_we) begin
        data_vld_q[data_addr] <= 1'b1;
      end
      if (stack_we) begin
        stack_vld_q[stack_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= req_i;
  end

  always_comb begin
    unique case (s1_q.tgt)
      smwg_pkg::TGT_TEXT:  mem_word = text_rv_q  ? text_rd_q  : '0;
      smwg_pkg::TGT_DATA:  mem_word = data_rv_q  ? data_rd_q  : '0;
      smwg_pkg::TGT_STACK: mem_word = stack_rv_q ? stack_rd_q : '0;
      default:             mem_word = '0;
    endcase
  end

  always_comb begin
    priority if (s1_q.status == smwg_pkg::ST_OK) begin
      src_word = mem_word;
    end else if (s1_q.status == smwg_pkg::ST_UNMAPPED || !s1_q.is_byte) begin
      src_word = fault_i;
    end else begin
      src_word = '0;
    end
  end

  always_comb begin
    unique case (s1_q.lane)
      2'd0:    lane_byte = src_word[7:0];
      2'd1:    lane_byte = src_word[15:8];
      2'd2:    lane_byte = src_word[23:16];
      default: lane_byte = src_word[31:24];
    endcase
  end

  always_comb begin
    res_word = s1_q.is_byte ? {{(smwg_pkg::WORD_W - 8){1'b0}}, lane_byte} : src_word;
    word_d   = (s1_q.op == smwg_pkg::OP_READ) ? res_word : '0;
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    status_q <= 3'(s1_q.status);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= pop_i;
      done_q   <= s1_vld_q;
    end
  end

  assign done_o      = done_q;
  assign read_word_o = word_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire
